FILE: rtl/core/dtc_pkg.sv
// shared types and constants for the dispersion tensor core
// no dependencies; imported by every module of the core
package dtc_pkg;

    localparam int FLUX_W     = 32;
    localparam int DISP_W     = 32;
    localparam int COEF_W     = 48;
    localparam int SQ_W       = 2 * FLUX_W;
    localparam int PROD_W     = SQ_W + DISP_W;
    localparam int FRAC_EXTRA = 16;
    localparam int NUM_W      = PROD_W + FRAC_EXTRA;
    localparam int ROOT_W     = 48;
    localparam int RAD_W      = 2 * ROOT_W + 2;
    localparam int DIV_LAT    = ROOT_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = QPTR_W + 1;

    localparam logic [COEF_W-1:0] COEF_MAX = '1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIFF_X  = 3'd0,
        CFG_DIFF_Y  = 3'd1,
        CFG_DIFF_Z  = 3'd2,
        CFG_ALPHA_L = 3'd3,
        CFG_ALPHA_T = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic signed [FLUX_W-1:0] flux_x;
        logic signed [FLUX_W-1:0] flux_y;
        logic signed [FLUX_W-1:0] flux_z;
        logic                     end_of_sweep;
    } t_in;

    typedef struct packed {
        logic [COEF_W-1:0] coef_xx;
        logic [COEF_W-1:0] coef_xy;
        logic [COEF_W-1:0] coef_xz;
        logic [COEF_W-1:0] coef_yy;
        logic [COEF_W-1:0] coef_yx;
        logic [COEF_W-1:0] coef_yz;
        logic [COEF_W-1:0] coef_zz;
        logic [COEF_W-1:0] coef_zx;
        logic [COEF_W-1:0] coef_zy;
        logic              sweep_done;
    } t_out;

    typedef struct packed {
        logic [COEF_W-1:0] diff_x;
        logic [COEF_W-1:0] diff_y;
        logic [COEF_W-1:0] diff_z;
        logic [DISP_W-1:0] alpha_l;
        logic [DISP_W-1:0] alpha_t;
    } t_cfg;

    // classified item: signs, squares and cross products (xy, xz, yz)
    typedef struct packed {
        logic [2:0]            neg;
        logic [2:0][SQ_W-1:0]  sq;
        logic [2:0][SQ_W-1:0]  prod;
        logic                  eos;
    } t_cls;

endpackage

FILE: rtl/core/dispersion_tensor_calc_core.sv
// top level of the dispersion tensor core: configuration registers and wiring
// depends on dtc_pkg, dtc_front, dtc_queue, dtc_back
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------
//  input    | i_valid / o_stall       | i_data  (flux x,y,z, end_of_sweep)
//  output   | o_valid / i_stall       | o_data  (nine tensor entries, sweep_done)
//  config   | i_cfg_we                | i_cfg_idx, i_cfg_data
//
//  one item per cycle unless o_stall or i_stall holds it; the path to the output
//  register runs through the 48-stage square root and the 49-stage dividers
//  a four-entry queue separates the front end from the back end pipeline
//  the back end pipeline freezes only while a finished item is held by i_stall
//  reset (synchronous, active low) clears control state and the config registers
module dispersion_tensor_calc_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  dtc_pkg::t_in                 i_data,
    output logic                         o_valid,
    input  logic                         i_stall,
    output dtc_pkg::t_out                o_data,
    input  logic                         i_cfg_we,
    input  logic [dtc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [dtc_pkg::COEF_W-1:0]   i_cfg_data
);
    import dtc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;
    t_cls w_entry;
    t_cls w_head;
    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;

    // register writes
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_DIFF_X:  n_cfg.diff_x  = i_cfg_data;
                CFG_DIFF_Y:  n_cfg.diff_y  = i_cfg_data;
                CFG_DIFF_Z:  n_cfg.diff_z  = i_cfg_data;
                CFG_ALPHA_L: n_cfg.alpha_l = i_cfg_data[DISP_W-1:0];
                CFG_ALPHA_T: n_cfg.alpha_t = i_cfg_data[DISP_W-1:0];
                default:     n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    dtc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_entry (w_entry)
    );

    dtc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    dtc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_empty (w_empty),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule

FILE: rtl/core/dtc_front.sv
// front end: input register, sign and magnitude split, squares and cross products
// depends on dtc_pkg
module dtc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  dtc_pkg::t_in  i_data,
    input  logic          i_full,
    output logic          o_push,
    output dtc_pkg::t_cls o_entry
);
    import dtc_pkg::*;

    t_in  r_f;
    logic r_f_v;
    logic n_f_v;
    logic w_take;
    logic [2:0][FLUX_W-1:0] w_raw;
    logic [2:0][FLUX_W-1:0] w_mag;

    // handshake toward the queue
    assign o_stall = r_f_v && i_full;
    assign o_push  = r_f_v && !i_full;
    assign w_take  = i_valid && !o_stall;

    always_comb begin
        n_f_v = r_f_v;
        if (w_take) begin
            n_f_v = 1'b1;
        end else if (o_push) begin
            n_f_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else begin
            r_f_v <= n_f_v;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_f <= i_data;
        end
    end

    // sign and magnitude, squares, cross products
    always_comb begin
        w_raw[0] = r_f.flux_x;
        w_raw[1] = r_f.flux_y;
        w_raw[2] = r_f.flux_z;
        for (int i = 0; i < 3; i++) begin
            o_entry.neg[i] = w_raw[i][FLUX_W-1];
            w_mag[i] = w_raw[i][FLUX_W-1] ? (~w_raw[i] + 1'b1) : w_raw[i];
            o_entry.sq[i] = SQ_W'(w_mag[i]) * SQ_W'(w_mag[i]);
        end
        o_entry.prod[0] = SQ_W'(w_mag[0]) * SQ_W'(w_mag[1]);
        o_entry.prod[1] = SQ_W'(w_mag[0]) * SQ_W'(w_mag[2]);
        o_entry.prod[2] = SQ_W'(w_mag[1]) * SQ_W'(w_mag[2]);
        o_entry.eos = r_f.end_of_sweep;
    end

endmodule

FILE: rtl/core/dtc_queue.sv
// short item queue between the front end and the arithmetic back end
// depends on dtc_pkg
module dtc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dtc_pkg::t_cls i_entry,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output dtc_pkg::t_cls o_head
);
    import dtc_pkg::*;

    t_cls               r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr;
    logic [QPTR_W-1:0]  r_rd;
    logic [QCNT_W-1:0]  r_cnt;
    logic [QCNT_W-1:0]  n_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    // fill count
    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(QDEPTH))
        else $error("queue count out of range");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");

    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue count did not follow a push");

endmodule

FILE: rtl/core/dtc_div.sv
// pipelined restoring divider, one quotient bit per stage, saturating quotient
// depends on dtc_pkg
module dtc_div (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [dtc_pkg::NUM_W-1:0]  i_num,
    input  logic [dtc_pkg::ROOT_W-1:0] i_den,
    output logic [dtc_pkg::COEF_W-1:0] o_quot
);
    import dtc_pkg::*;

    localparam int HI_W = NUM_W - COEF_W;

    logic [ROOT_W-1:0] r_rem [0:COEF_W-1];
    logic [COEF_W-1:0] r_low [0:COEF_W-1];
    logic [ROOT_W-1:0] r_den [0:COEF_W-1];
    logic [COEF_W-1:0] r_quo [0:COEF_W];
    logic              r_sat [0:COEF_W];
    logic [HI_W-1:0]   w_hi;

    assign w_hi = i_num[NUM_W-1:COEF_W];

    // entry stage: overflow check against den * 2^48
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sat[0] <= (w_hi >= HI_W'(i_den));
            r_rem[0] <= w_hi[ROOT_W-1:0];
            r_low[0] <= i_num[COEF_W-1:0];
            r_den[0] <= i_den;
            r_quo[0] <= '0;
        end
    end

    // one quotient bit per stage
    for (genvar k = 0; k < COEF_W; k++) begin : g_step
        logic [ROOT_W:0] w_part;
        logic [ROOT_W:0] w_diff;
        logic            w_ge;

        always_comb begin
            w_part = {r_rem[k], r_low[k][COEF_W-1]};
            w_diff = w_part - {1'b0, r_den[k]};
            w_ge   = (w_part >= {1'b0, r_den[k]});
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[k+1] <= {r_quo[k][COEF_W-2:0], w_ge};
                r_sat[k+1] <= r_sat[k];
            end
        end

        // remainder, dividend bits and divisor are not needed past the last stage
        if (k < COEF_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1] <= w_ge ? w_diff[ROOT_W-1:0] : w_part[ROOT_W-1:0];
                    r_low[k+1] <= {r_low[k][COEF_W-2:0], 1'b0};
                    r_den[k+1] <= r_den[k];
                end
            end
        end
    end

    assign o_quot = r_sat[COEF_W] ? COEF_MAX : r_quo[COEF_W];

endmodule

FILE: rtl/core/dtc_back.sv
// back end: products, numerators, pipelined square root of |q|, six dividers,
// diffusion add and clamps; depends on dtc_pkg and dtc_div
module dtc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  dtc_pkg::t_cfg i_cfg,
    input  logic          i_empty,
    input  dtc_pkg::t_cls i_head,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output dtc_pkg::t_out o_data
);
    import dtc_pkg::*;

    typedef struct packed {
        logic [5:0][NUM_W-1:0] num;
        logic [2:0]            kill;
        logic                  zero;
        logic                  eos;
        logic [RAD_W-1:0]      rem;
        logic [ROOT_W-1:0]     root;
    } t_rt;

    typedef struct packed {
        logic [2:0] kill;
        logic       zero;
        logic       eos;
    } t_sd;

    logic                   w_en;
    logic [DISP_W-1:0]      r_dabs;
    logic                   r_dneg;

    // stage p: partial products
    logic [2:0][SQ_W-1:0]   r_p_l_lo, r_p_l_hi, r_p_t_lo, r_p_t_hi, r_p_o_lo, r_p_o_hi;
    logic [SQ_W-1:0]        r_p_s;
    logic [2:0]             r_p_kill;
    logic                   r_p_eos;

    // stage p2: full products
    logic [2:0][PROD_W-1:0] r_q_l, r_q_t, r_q_o;
    logic [SQ_W-1:0]        r_q_s;
    logic [2:0]             r_q_kill;
    logic                   r_q_eos;

    t_rt                    r_rt [0:ROOT_W];
    t_sd                    r_sd [0:DIV_LAT-1];
    logic [5:0][COEF_W-1:0] w_quot;
    logic [2:0][COEF_W-1:0] w_diff;
    logic [2:0][COEF_W-1:0] w_diag;
    logic [2:0][COEF_W-1:0] w_off;
    logic [COEF_W:0]        w_sum [3];
    t_out                   r_out;

    logic                   r_v_p, r_v_p2, r_v_out;
    logic [ROOT_W:0]        r_v_rt;
    logic [DIV_LAT-1:0]     r_v_sd;

    // whole pipeline advances unless a result is held
    assign w_en    = !(r_v_out && i_stall);
    assign o_pop   = w_en && !i_empty;
    assign o_valid = r_v_out;
    assign o_data  = r_out;

    // dispersivity difference
    always_ff @(posedge i_clk) begin
        r_dneg <= (i_cfg.alpha_t > i_cfg.alpha_l);
        r_dabs <= (i_cfg.alpha_t > i_cfg.alpha_l) ? (i_cfg.alpha_t - i_cfg.alpha_l)
                                                  : (i_cfg.alpha_l - i_cfg.alpha_t);
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_p   <= 1'b0;
            r_v_p2  <= 1'b0;
            r_v_rt  <= '0;
            r_v_sd  <= '0;
            r_v_out <= 1'b0;
        end else if (w_en) begin
            r_v_p   <= o_pop;
            r_v_p2  <= r_v_p;
            r_v_rt  <= {r_v_rt[ROOT_W-1:0], r_v_p2};
            r_v_sd  <= {r_v_sd[DIV_LAT-2:0], r_v_rt[ROOT_W]};
            r_v_out <= r_v_sd[DIV_LAT-1];
        end
    end

    // partial products, 32 by 32 each
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_p_l_lo[i] <= SQ_W'(i_cfg.alpha_l) * SQ_W'(i_head.sq[i][DISP_W-1:0]);
                r_p_l_hi[i] <= SQ_W'(i_cfg.alpha_l) * SQ_W'(i_head.sq[i][SQ_W-1:DISP_W]);
                r_p_t_lo[i] <= SQ_W'(i_cfg.alpha_t) * SQ_W'(i_head.sq[i][DISP_W-1:0]);
                r_p_t_hi[i] <= SQ_W'(i_cfg.alpha_t) * SQ_W'(i_head.sq[i][SQ_W-1:DISP_W]);
                r_p_o_lo[i] <= SQ_W'(r_dabs) * SQ_W'(i_head.prod[i][DISP_W-1:0]);
                r_p_o_hi[i] <= SQ_W'(r_dabs) * SQ_W'(i_head.prod[i][SQ_W-1:DISP_W]);
            end
            r_p_s       <= i_head.sq[0] + i_head.sq[1] + i_head.sq[2];
            r_p_kill[0] <= r_dneg ^ i_head.neg[0] ^ i_head.neg[1];
            r_p_kill[1] <= r_dneg ^ i_head.neg[0] ^ i_head.neg[2];
            r_p_kill[2] <= r_dneg ^ i_head.neg[1] ^ i_head.neg[2];
            r_p_eos     <= i_head.eos;
        end
    end

    // merge partial products
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_q_l[i] <= PROD_W'(r_p_l_lo[i]) + (PROD_W'(r_p_l_hi[i]) << DISP_W);
                r_q_t[i] <= PROD_W'(r_p_t_lo[i]) + (PROD_W'(r_p_t_hi[i]) << DISP_W);
                r_q_o[i] <= PROD_W'(r_p_o_lo[i]) + (PROD_W'(r_p_o_hi[i]) << DISP_W);
            end
            r_q_s    <= r_p_s;
            r_q_kill <= r_p_kill;
            r_q_eos  <= r_p_eos;
        end
    end

    // numerators and root radicand
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rt[0].num[0] <= {r_q_l[0] + r_q_t[1] + r_q_t[2], FRAC_EXTRA'(0)};
            r_rt[0].num[1] <= {r_q_l[1] + r_q_t[0] + r_q_t[2], FRAC_EXTRA'(0)};
            r_rt[0].num[2] <= {r_q_l[2] + r_q_t[0] + r_q_t[1], FRAC_EXTRA'(0)};
            r_rt[0].num[3] <= {r_q_o[0], FRAC_EXTRA'(0)};
            r_rt[0].num[4] <= {r_q_o[1], FRAC_EXTRA'(0)};
            r_rt[0].num[5] <= {r_q_o[2], FRAC_EXTRA'(0)};
            r_rt[0].kill   <= r_q_kill;
            r_rt[0].zero   <= (r_q_s == '0);
            r_rt[0].eos    <= r_q_eos;
            r_rt[0].rem    <= RAD_W'({r_q_s, 32'd0});
            r_rt[0].root   <= '0;
        end
    end

    // square root, one result bit per stage
    for (genvar k = 0; k < ROOT_W; k++) begin : g_root
        localparam int B = ROOT_W - 1 - k;
        logic [RAD_W-1:0] w_delta;
        logic             w_fit;
        t_rt              w_next;

        always_comb begin
            w_delta = (RAD_W'(r_rt[k].root) << (B + 1)) + (RAD_W'(1) << (2 * B));
            w_fit   = (r_rt[k].rem >= w_delta);
            w_next  = r_rt[k];
            if (w_fit) begin
                w_next.rem  = r_rt[k].rem - w_delta;
                w_next.root = r_rt[k].root | (ROOT_W'(1) << B);
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_rt[k+1] <= w_next;
            end
        end
    end

    // six dividers by |q|
    for (genvar j = 0; j < 6; j++) begin : g_div
        dtc_div u_div (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_num  (r_rt[ROOT_W].num[j]),
            .i_den  (r_rt[ROOT_W].root),
            .o_quot (w_quot[j])
        );
    end

    // side flags alongside the dividers
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sd[0] <= '{kill: r_rt[ROOT_W].kill, zero: r_rt[ROOT_W].zero,
                         eos: r_rt[ROOT_W].eos};
            for (int i = 1; i < DIV_LAT; i++) begin
                r_sd[i] <= r_sd[i-1];
            end
        end
    end

    // diffusion add with saturation, off-diagonal clamp
    always_comb begin
        w_diff[0] = i_cfg.diff_x;
        w_diff[1] = i_cfg.diff_y;
        w_diff[2] = i_cfg.diff_z;
        for (int i = 0; i < 3; i++) begin
            w_sum[i] = {1'b0, w_diff[i]} + {1'b0, w_quot[i]};
            if (r_sd[DIV_LAT-1].zero) begin
                w_diag[i] = w_diff[i];
            end else if (w_sum[i][COEF_W]) begin
                w_diag[i] = COEF_MAX;
            end else begin
                w_diag[i] = w_sum[i][COEF_W-1:0];
            end
            w_off[i] = (r_sd[DIV_LAT-1].zero || r_sd[DIV_LAT-1].kill[i]) ? '0 : w_quot[i+3];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.coef_xx    <= w_diag[0];
            r_out.coef_xy    <= w_off[0];
            r_out.coef_xz    <= w_off[1];
            r_out.coef_yy    <= w_diag[1];
            r_out.coef_yx    <= w_off[0];
            r_out.coef_yz    <= w_off[2];
            r_out.coef_zz    <= w_diag[2];
            r_out.coef_zx    <= w_off[1];
            r_out.coef_zy    <= w_off[2];
            r_out.sweep_done <= r_sd[DIV_LAT-1].eos;
        end
    end

    a_zero_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v_rt[ROOT_W] |-> (r_rt[ROOT_W].zero == (r_rt[ROOT_W].root == '0)))
        else $error("zero discharge flag disagrees with root");

endmodule
